[src/ilt_pkg.sv]
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared defaults and request codes for the indexed list table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilt_pkg;

    // default geometry
    localparam int DEPTH_DEF      = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    // request codes
    localparam int REQ_W = 3;

    localparam logic [REQ_W-1:0] REQ_ADD       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GET       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FIND      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DEL_RANGE = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SET_COUNT = 3'd7;

endpackage

[src/ilt_obuf.sv]
// ----------------------------------------------------------------------------
// ilt_obuf
// One-word output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilt_obuf #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [DW-1:0] out_data
);

    logic          vld_reg;
    logic          vld_next;
    logic [DW-1:0] data_reg;

    // room when empty or when the held word leaves this cycle
    assign in_ready = !vld_reg || !out_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_ready)
        begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

[src/ilt_ctrl.sv]
// ----------------------------------------------------------------------------
// ilt_ctrl
// Request sequencer and entry memory: reads, shifts, searches and reports
// entries through one read and one write port, one request at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilt_ctrl
    import ilt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int PW        = CW + 1,
    localparam int DW        = 3 + PW + CW + 2 * ITEM_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [CW-1:0]         position_in,
    input  logic [ITEM_WIDTH-1:0] item_value,
    input  logic [CW-1:0]         amount,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [DW-1:0]         res_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_EMIT  = 3'd2;
    localparam logic [2:0] ST_MOVE  = 3'd3;
    localparam logic [2:0] ST_FIND  = 3'd4;
    localparam logic [2:0] ST_ERD   = 3'd5;
    localparam logic [2:0] ST_EWAIT = 3'd6;
    localparam logic [2:0] ST_FILL  = 3'd7;

    // entry memory, one read and one write port, registered read
    logic [ITEM_WIDTH-1:0] entry_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rd_data_reg;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [ITEM_WIDTH-1:0] mem_wr_data;

    // control state
    logic [2:0]    state_reg,  state_next;
    logic [CW-1:0] fill_reg,   fill_next;
    logic          pend_reg,   pend_next;

    // request context
    logic [REQ_W-1:0]      op_reg,  op_next;
    logic [ITEM_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]         pos_reg, pos_next;

    // walk counters: shift, search and zero fill
    logic [AW-1:0] mv_src_reg,    mv_src_next;
    logic [CW-1:0] mv_left_reg,   mv_left_next;
    logic          mv_down_reg,   mv_down_next;
    logic [CW-1:0] mv_dist_reg,   mv_dist_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;

    // report loop for removed entries
    logic [AW-1:0] em_addr_reg, em_addr_next;
    logic [CW-1:0] em_left_reg, em_left_next;
    logic          em_down_reg, em_down_next;

    // result word under construction
    logic                  r_ok_reg,   r_ok_next;
    logic [PW-1:0]         r_pos_reg,  r_pos_next;
    logic [ITEM_WIDTH-1:0] r_rd_reg,   r_rd_next;
    logic [CW-1:0]         r_cnt_reg,  r_cnt_next;
    logic                  r_rv_reg,   r_rv_next;
    logic [ITEM_WIDTH-1:0] r_rem_reg,  r_rem_next;
    logic                  r_last_reg, r_last_next;

    // helpers
    logic [CW-1:0] fill_dec_w;
    logic [CW-1:0] fill_inc_w;
    logic [CW-1:0] span_w;
    logic [CW-1:0] clamp_w;
    logic [CW-1:0] del_left_w;
    logic [CW-1:0] pos_inc_w;
    logic [CW-1:0] rng_end_w;
    logic [AW-1:0] mv_dst_w;
    logic          match_w;
    logic          move_op_w;

    assign fill_dec_w = fill_reg - CW'(1);
    assign fill_inc_w = fill_reg + CW'(1);
    assign span_w     = fill_reg - position_in;
    assign clamp_w    = (amount > span_w) ? span_w : amount;
    assign del_left_w = fill_dec_w - position_in;
    assign pos_inc_w  = position_in + CW'(1);
    assign rng_end_w  = position_in + clamp_w;
    assign mv_dst_w   = mv_down_reg ? (pend_addr_reg + AW'(1))
                                    : (pend_addr_reg - mv_dist_reg[AW-1:0]);
    assign match_w    = pend_reg && (rd_data_reg == val_reg);
    assign move_op_w  = (op_reg == REQ_DELETE) || (op_reg == REQ_DEL_RANGE);

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res_data  = {r_ok_reg, r_pos_reg, r_rd_reg, r_cnt_reg,
                        r_rv_reg, r_rem_reg, r_last_reg};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        mv_src_next    = mv_src_reg;
        mv_left_next   = mv_left_reg;
        mv_down_next   = mv_down_reg;
        mv_dist_next   = mv_dist_reg;
        pend_addr_next = pend_addr_reg;
        em_addr_next   = em_addr_reg;
        em_left_next   = em_left_reg;
        em_down_next   = em_down_reg;
        r_ok_next      = r_ok_reg;
        r_pos_next     = r_pos_reg;
        r_rd_next      = r_rd_reg;
        r_cnt_next     = r_cnt_reg;
        r_rv_next      = r_rv_reg;
        r_rem_next     = r_rem_reg;
        r_last_next    = r_last_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = mv_src_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = mv_src_reg;
        mem_wr_data    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req_type;
                    val_next     = item_value;
                    pos_next     = position_in;
                    // failure word unless the request succeeds
                    r_ok_next    = 1'b0;
                    r_pos_next   = '1;
                    r_rd_next    = '0;
                    r_cnt_next   = fill_reg;
                    r_rv_next    = 1'b0;
                    r_rem_next   = '0;
                    r_last_next  = 1'b1;
                    mv_left_next = '0;
                    pend_next    = 1'b0;
                    state_next   = ST_EMIT;

                    unique case (req_type)
                        REQ_ADD:
                        begin
                            if (fill_reg < DEPTH_C)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = fill_reg[AW-1:0];
                                mem_wr_data = item_value;
                                fill_next   = fill_inc_w;
                                r_ok_next   = 1'b1;
                                r_pos_next  = PW'(fill_reg);
                                r_cnt_next  = fill_inc_w;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if ((position_in <= fill_reg) && (fill_reg < DEPTH_C))
                            begin
                                fill_next    = fill_inc_w;
                                r_ok_next    = 1'b1;
                                r_pos_next   = PW'(position_in);
                                r_cnt_next   = fill_inc_w;
                                // shift the tail up, top entry first
                                mv_src_next  = fill_dec_w[AW-1:0];
                                mv_left_next = span_w;
                                mv_down_next = 1'b1;
                                state_next   = ST_MOVE;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (position_in < fill_reg)
                            begin
                                fill_next    = fill_dec_w;
                                r_ok_next    = 1'b1;
                                r_rv_next    = 1'b1;
                                r_cnt_next   = fill_dec_w;
                                mem_rd_en    = 1'b1;
                                mem_rd_addr  = position_in[AW-1:0];
                                // tail shifts down after the report
                                mv_src_next  = pos_inc_w[AW-1:0];
                                mv_left_next = del_left_w;
                                mv_down_next = 1'b0;
                                mv_dist_next = CW'(1);
                                state_next   = ST_RD;
                            end
                        end
                        REQ_SET:
                        begin
                            if (position_in < fill_reg)
                            begin
                                r_ok_next   = 1'b1;
                                r_rv_next   = 1'b1;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = position_in[AW-1:0];
                                state_next  = ST_RD;
                            end
                        end
                        REQ_GET:
                        begin
                            if (position_in < fill_reg)
                            begin
                                r_ok_next   = 1'b1;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = position_in[AW-1:0];
                                state_next  = ST_RD;
                            end
                        end
                        REQ_FIND:
                        begin
                            // search from the top entry downward
                            mv_src_next  = fill_dec_w[AW-1:0];
                            mv_left_next = fill_reg;
                            mv_down_next = 1'b1;
                            state_next   = ST_FIND;
                        end
                        REQ_DEL_RANGE:
                        begin
                            if (position_in <= fill_reg)
                            begin
                                r_ok_next = 1'b1;
                                if (clamp_w != '0)
                                begin
                                    r_rv_next    = 1'b1;
                                    fill_next    = fill_reg - clamp_w;
                                    r_cnt_next   = fill_reg - clamp_w;
                                    em_addr_next = position_in[AW-1:0];
                                    em_left_next = clamp_w;
                                    em_down_next = 1'b0;
                                    mv_src_next  = rng_end_w[AW-1:0];
                                    mv_left_next = span_w - clamp_w;
                                    mv_down_next = 1'b0;
                                    mv_dist_next = clamp_w;
                                    state_next   = ST_ERD;
                                end
                            end
                        end
                        REQ_SET_COUNT:
                        begin
                            if (amount <= DEPTH_C)
                            begin
                                r_ok_next  = 1'b1;
                                fill_next  = amount;
                                r_cnt_next = amount;
                                if (amount >= fill_reg)
                                begin
                                    // zero the new entries
                                    mv_src_next  = fill_reg[AW-1:0];
                                    mv_left_next = amount - fill_reg;
                                    state_next   = ST_FILL;
                                end
                                else
                                begin
                                    // report dropped entries, top first
                                    r_rv_next    = 1'b1;
                                    em_addr_next = fill_dec_w[AW-1:0];
                                    em_left_next = fill_reg - amount;
                                    em_down_next = 1'b1;
                                    state_next   = ST_ERD;
                                end
                            end
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                // single-entry read has landed
                if (op_reg == REQ_GET)
                begin
                    r_rd_next = rd_data_reg;
                end
                else
                begin
                    r_rem_next = rd_data_reg;
                end
                if (op_reg == REQ_SET)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pos_reg[AW-1:0];
                    mem_wr_data = val_reg;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (res_ready)
                begin
                    if (!r_last_reg)
                    begin
                        state_next = ST_ERD;
                    end
                    else if (move_op_w)
                    begin
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_MOVE:
            begin
                // write back last cycle's read while issuing the next one
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = mv_dst_w;
                    mem_wr_data = rd_data_reg;
                end
                if (mv_left_reg != '0)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = mv_src_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = mv_src_reg;
                    mv_src_next    = mv_down_reg ? (mv_src_reg - AW'(1))
                                                 : (mv_src_reg + AW'(1));
                    mv_left_next   = mv_left_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (op_reg == REQ_INSERT)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = pos_reg[AW-1:0];
                            mem_wr_data = val_reg;
                            state_next  = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_FIND:
            begin
                if (match_w)
                begin
                    r_ok_next  = 1'b1;
                    r_pos_next = PW'(pend_addr_reg);
                    pend_next  = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (mv_left_reg == '0)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = mv_src_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = mv_src_reg;
                    mv_src_next    = mv_src_reg - AW'(1);
                    mv_left_next   = mv_left_reg - CW'(1);
                end
            end

            ST_ERD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = em_addr_reg;
                state_next  = ST_EWAIT;
            end

            ST_EWAIT:
            begin
                r_rem_next   = rd_data_reg;
                r_last_next  = (em_left_reg == CW'(1));
                em_left_next = em_left_reg - CW'(1);
                em_addr_next = em_down_reg ? (em_addr_reg - AW'(1))
                                           : (em_addr_reg + AW'(1));
                state_next   = ST_EMIT;
            end

            ST_FILL:
            begin
                if (mv_left_reg != '0)
                begin
                    mem_wr_en    = 1'b1;
                    mem_wr_addr  = mv_src_reg;
                    mem_wr_data  = '0;
                    mv_src_next  = mv_src_reg + AW'(1);
                    mv_left_next = mv_left_reg - CW'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    // context and result registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        mv_src_reg    <= mv_src_next;
        mv_left_reg   <= mv_left_next;
        mv_down_reg   <= mv_down_next;
        mv_dist_reg   <= mv_dist_next;
        pend_addr_reg <= pend_addr_next;
        em_addr_reg   <= em_addr_next;
        em_left_reg   <= em_left_next;
        em_down_reg   <= em_down_next;
        r_ok_reg      <= r_ok_next;
        r_pos_reg     <= r_pos_next;
        r_rd_reg      <= r_rd_next;
        r_cnt_reg     <= r_cnt_next;
        r_rv_reg      <= r_rv_next;
        r_rem_reg     <= r_rem_next;
        r_last_reg    <= r_last_next;
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            entry_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= entry_mem[mem_rd_addr];
        end
    end

endmodule

[src/indexed_list_table.sv]
// ----------------------------------------------------------------------------
// indexed_list_table
// Bounded ordered list of words held in one entry memory. One request is
// worked at a time. Insert and delete move every later entry one place per
// cycle through the memory's one read and one write port, find reads the
// entries from the top down (one compare per entry read), a range delete or
// a shrinking set count reads, captures and hands off each reported entry in
// turn, a range delete then moves the entries above the range down, and a
// growing set count writes one zero per cycle. A result-side stall holds
// the request in progress until the result word is taken.
// Each removed or overwritten entry comes out as its own result word; the
// word with last_result high closes the request. No clearing pass is needed
// after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_table
    import ilt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int PW        = CW + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [CW-1:0]         position_in,
    input  logic [ITEM_WIDTH-1:0] item_value,
    input  logic [CW-1:0]         amount,
    // result channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic                  ok,
    output logic signed [PW-1:0]  position_out,
    output logic [ITEM_WIDTH-1:0] read_value,
    output logic [CW-1:0]         entry_count,
    output logic                  removed_valid,
    output logic [ITEM_WIDTH-1:0] removed_value,
    output logic                  last_result
);

    localparam int DW = 3 + PW + CW + 2 * ITEM_WIDTH;

    logic          res_valid_w;
    logic          res_ready_w;
    logic [DW-1:0] res_data_w;
    logic [DW-1:0] rsp_data_w;
    logic [PW-1:0] pos_w;

    // sequencer and entry memory
    ilt_ctrl #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .position_in (position_in),
        .item_value  (item_value),
        .amount      (amount),
        .res_valid   (res_valid_w),
        .res_ready   (res_ready_w),
        .res_data    (res_data_w)
    );

    // result word register
    ilt_obuf #(
        .DW (DW)
    ) u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid_w),
        .in_ready  (res_ready_w),
        .in_data   (res_data_w),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (rsp_data_w)
    );

    assign {ok, pos_w, read_value, entry_count,
            removed_valid, removed_value, last_result} = rsp_data_w;
    assign position_out = $signed(pos_w);

`ifndef ASSERT_OFF
    // a taken request always keeps the block busy in the cycle after it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request channel open right after an accepted request");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (entry_count <= CW'(DEPTH)))
        else $error("entry_count above capacity");

    // a failed request reports nothing and no position
    a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !ok) |-> (!removed_valid && (pos_w == '1) && last_result))
        else $error("failed request word malformed");

    // only reporting loops produce more than one word
    a_multi_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !last_result) |-> (removed_valid && ok))
        else $error("non-final word without a removed entry");
`endif

endmodule
